// ===== hw/rtl/identifier_list_validator_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef IDENTIFIER_LIST_VALIDATOR_CORE_DEFINES_SVH
`define IDENTIFIER_LIST_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ILV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ILV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ilv_pkg.sv =====
package ilv_pkg;

  localparam int unsigned MAX_LENGTH = 1024;
  localparam int unsigned TEXT_W     = 11;
  localparam int unsigned IDENT_W    = 7;

  localparam logic [TEXT_W:0]    MAX_LEN_X  = (TEXT_W + 1)'(MAX_LENGTH);
  localparam logic [TEXT_W-1:0]  TEXT_SAT   = '1;
  localparam logic [IDENT_W-1:0] IDENT_MAX  = 7'd63;
  localparam logic [IDENT_W-1:0] IDENT_OVER = 7'd64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_UNQ   = 3'd1,
    PH_QIN   = 3'd2,
    PH_QPEND = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [IDENT_W-1:0]  ident_len;
    logic [TEXT_W-1:0]   text_len;
    logic                failed;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_LEAD,
    ident_len: '0,
    text_len:  '0,
    failed:    1'b0
  };

endpackage

// ===== hw/rtl/ilv_step.sv =====
module ilv_step (
  input  ilv_pkg::parse_state_t cur,
  input  logic [7:0]            ch,
  output ilv_pkg::parse_state_t nxt,
  output logic                  ok
);

  function automatic logic is_alpha_us(input logic [7:0] c);
    is_alpha_us = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
                  (c == 8'h5f);
  endfunction

  function automatic logic is_ident_rest(input logic [7:0] c);
    is_ident_rest = is_alpha_us(c) || (c >= 8'h30 && c <= 8'h39) || (c == 8'h24);
  endfunction

  logic [ilv_pkg::TEXT_W:0]    text_inc;
  logic [ilv_pkg::IDENT_W-1:0] ident_inc;
  logic                        ident_ovf;
  logic                        pre_fail;

  assign text_inc  = {1'b0, cur.text_len} + 1'b1;
  assign ident_inc = cur.ident_len + 1'b1;
  assign ident_ovf = ident_inc > ilv_pkg::IDENT_MAX;
  assign pre_fail  = cur.failed || (text_inc > ilv_pkg::MAX_LEN_X) ||
                     (ch < ilv_pkg::CH_SPACE) || (ch == ilv_pkg::CH_DEL);

  always_comb begin
    nxt        = cur;
    nxt.failed = pre_fail;
    nxt.text_len = text_inc[ilv_pkg::TEXT_W] ? ilv_pkg::TEXT_SAT
                                             : text_inc[ilv_pkg::TEXT_W-1:0];
    if (!pre_fail) begin
      unique case (cur.phase)
        ilv_pkg::PH_LEAD: begin
          if (ch == ilv_pkg::CH_SPACE) begin
            nxt.phase = ilv_pkg::PH_LEAD;
          end else if (ch == ilv_pkg::CH_QUOTE) begin
            nxt.phase     = ilv_pkg::PH_QIN;
            nxt.ident_len = '0;
          end else if (is_alpha_us(ch)) begin
            nxt.phase     = ilv_pkg::PH_UNQ;
            nxt.ident_len = 7'd1;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        ilv_pkg::PH_UNQ: begin
          if (is_ident_rest(ch)) begin
            nxt.ident_len = ident_ovf ? ilv_pkg::IDENT_OVER : ident_inc;
            nxt.failed    = ident_ovf;
          end else if (ch == ilv_pkg::CH_SPACE) begin
            nxt.phase = ilv_pkg::PH_TRAIL;
          end else if (ch == ilv_pkg::CH_COMMA) begin
            nxt.phase = ilv_pkg::PH_LEAD;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        ilv_pkg::PH_QIN: begin
          if (ch == ilv_pkg::CH_QUOTE) begin
            nxt.phase = ilv_pkg::PH_QPEND;
          end else begin
            nxt.ident_len = ident_ovf ? ilv_pkg::IDENT_OVER : ident_inc;
            nxt.failed    = ident_ovf;
          end
        end
        ilv_pkg::PH_QPEND: begin
          // A second quote is an escaped quote; a space or comma closes a non-empty identifier, anything else fails.
          if (ch == ilv_pkg::CH_QUOTE) begin
            nxt.phase     = ilv_pkg::PH_QIN;
            nxt.ident_len = ident_ovf ? ilv_pkg::IDENT_OVER : ident_inc;
            nxt.failed    = ident_ovf;
          end else if (cur.ident_len == '0) begin
            nxt.failed = 1'b1;
          end else if (ch == ilv_pkg::CH_SPACE) begin
            nxt.phase = ilv_pkg::PH_TRAIL;
          end else if (ch == ilv_pkg::CH_COMMA) begin
            nxt.phase = ilv_pkg::PH_LEAD;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        ilv_pkg::PH_TRAIL: begin
          if (ch == ilv_pkg::CH_SPACE) begin
            nxt.phase = ilv_pkg::PH_TRAIL;
          end else if (ch == ilv_pkg::CH_COMMA) begin
            nxt.phase = ilv_pkg::PH_LEAD;
          end else begin
            nxt.failed = 1'b1;
          end
        end
        default: begin
          nxt.failed = 1'b1;
        end
      endcase
    end
  end

  assign ok = !nxt.failed &&
              ((nxt.phase == ilv_pkg::PH_UNQ) || (nxt.phase == ilv_pkg::PH_TRAIL) ||
               ((nxt.phase == ilv_pkg::PH_QPEND) && (nxt.ident_len != '0)));

endmodule

// ===== hw/rtl/ilv_out_reg.sv =====
module ilv_out_reg (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic load_res,
  output logic free,
  output logic out_valid,
  input  logic out_stall,
  output logic out_valid_res
);

  logic valid_r;
  logic valid_nxt;
  logic res_r;

  // The register can take a new beat when empty or when its beat leaves now.
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid     = valid_r;
  assign out_valid_res = res_r;

endmodule

// ===== hw/rtl/identifier_list_validator_core.sv =====
// Channel   Direction  Ports                          Beat
// in        input      in_valid in_stall in_ch in_last  one text byte
// out       output     out_valid out_stall out_valid_res  verdict on final byte
//
// One byte per cycle while in_stall is low; a verdict passes the input register, the parse step
// and the result register after its final byte is accepted.
// Reset clears the parse state, the input register and the result register.
// in_stall rises only when a final byte waits in the input register while a
// stalled verdict still occupies the result register.
module identifier_list_validator_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_valid_res
);

  logic                  in_v_r;
  logic                  in_v_nxt;
  logic [7:0]            ch_r;
  logic                  last_r;
  logic                  in_take;
  logic                  advance;
  logic                  out_free;
  logic                  step_ok;
  ilv_pkg::parse_state_t state_r;
  ilv_pkg::parse_state_t state_nxt;
  ilv_pkg::parse_state_t step_state;

  assign advance  = in_v_r && (!last_r || out_free);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  ilv_step u_step (
    .cur (state_r),
    .ch  (ch_r),
    .nxt (step_state),
    .ok  (step_ok)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (advance) begin
      state_nxt = last_r ? ilv_pkg::STATE_RESET : step_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      state_r <= ilv_pkg::STATE_RESET;
    end else begin
      in_v_r  <= in_v_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
  end

  ilv_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (advance && last_r),
    .load_res      (step_ok),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res)
  );

endmodule

// ===== hw/rtl/ilv_checker.sv =====
`include "identifier_list_validator_core_defines.svh"

module ilv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_ch,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_valid_res
);

  // A stalled verdict stays presented.
  `ILV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A stalled verdict keeps its value.
  `ILV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_valid_res))

  // The input only backs up behind a stalled verdict.
  `ILV_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // A stall needs a byte held from an earlier beat.
  `ILV_ASSERT_IMPL(a_stall_held, clk, rst_n, in_stall,
                   $past(in_valid && !in_stall) || $past(in_stall))

  // A stalled input beat is held unchanged by the sender.
  `ILV_ASSERT_NEXT(a_in_stable, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_ch) && $stable(in_last))

endmodule

bind identifier_list_validator_core ilv_checker u_ilv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_ch         (in_ch),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_valid_res (out_valid_res)
);
